@@ rtl/core/arabic_contextual_shaper_unit_macros.svh @@
// assertion macros shared by the shaper checker
`ifndef ARABIC_CONTEXTUAL_SHAPER_UNIT_MACROS_SVH
`define ARABIC_CONTEXTUAL_SHAPER_UNIT_MACROS_SVH

// implication property checked on every rising edge outside reset
`define ACS_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ACS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/core/acs_pkg.sv @@
// shared types, constants and letter tables of the arabic shaper
`default_nettype none

package acs_pkg;

    // codepoints with a role of their own
    localparam logic [15:0] LETTER_FIRST   = 16'h0621;
    localparam logic [15:0] LETTER_LAST    = 16'h064A;
    localparam logic [15:0] LAM            = 16'h0644;
    localparam logic [15:0] TATWEEL        = 16'h0640;
    localparam logic [15:0] HARAKA_FIRST   = 16'h064B;
    localparam logic [15:0] HARAKA_LAST    = 16'h065F;
    localparam logic [15:0] SUPERSCRIPT_ALEF = 16'h0670;
    localparam logic [15:0] QURANIC_FIRST  = 16'h06D6;
    localparam logic [15:0] QURANIC_LAST   = 16'h06ED;
    localparam logic [15:0] ALEF_MADDA     = 16'h0622;
    localparam logic [15:0] ALEF_HAMZA_UP  = 16'h0623;
    localparam logic [15:0] ALEF_HAMZA_LOW = 16'h0625;
    localparam logic [15:0] ALEF_PLAIN     = 16'h0627;
    localparam logic [15:0] LIG_MADDA      = 16'hFEF5;
    localparam logic [15:0] LIG_HAMZA_UP   = 16'hFEF7;
    localparam logic [15:0] LIG_HAMZA_LOW  = 16'hFEF9;
    localparam logic [15:0] LIG_PLAIN      = 16'hFEFB;

    // joining classes
    localparam logic [1:0] JC_NONE  = 2'd0;
    localparam logic [1:0] JC_RIGHT = 2'd1;
    localparam logic [1:0] JC_DUAL  = 2'd2;

    // presentation form offsets from the isolated form
    localparam logic [1:0] FORM_ISOLATED = 2'd0;
    localparam logic [1:0] FORM_FINAL    = 2'd1;
    localparam logic [1:0] FORM_INITIAL  = 2'd2;
    localparam logic [1:0] FORM_MEDIAL   = 2'd3;

    // what the classifier tells about one codepoint
    typedef struct packed {
        logic        transparent;
        logic        letter;
        logic        joins_fwd;
        logic        joins_back;
        logic [1:0]  jclass;
        logic [15:0] iso;
        logic [15:0] lig;
    } code_class_t;

    // isolated presentation form per letter index, zero for the gap
    function automatic logic [15:0] iso_form(input logic [5:0] idx);
        logic [15:0] f;
        case (idx)
            6'd0:    f = 16'hFE80;
            6'd1:    f = 16'hFE81;
            6'd2:    f = 16'hFE83;
            6'd3:    f = 16'hFE85;
            6'd4:    f = 16'hFE87;
            6'd5:    f = 16'hFE89;
            6'd6:    f = 16'hFE8D;
            6'd7:    f = 16'hFE8F;
            6'd8:    f = 16'hFE93;
            6'd9:    f = 16'hFE95;
            6'd10:   f = 16'hFE99;
            6'd11:   f = 16'hFE9D;
            6'd12:   f = 16'hFEA1;
            6'd13:   f = 16'hFEA5;
            6'd14:   f = 16'hFEA9;
            6'd15:   f = 16'hFEAB;
            6'd16:   f = 16'hFEAD;
            6'd17:   f = 16'hFEAF;
            6'd18:   f = 16'hFEB1;
            6'd19:   f = 16'hFEB5;
            6'd20:   f = 16'hFEB9;
            6'd21:   f = 16'hFEBD;
            6'd22:   f = 16'hFEC1;
            6'd23:   f = 16'hFEC5;
            6'd24:   f = 16'hFEC9;
            6'd25:   f = 16'hFECD;
            6'd32:   f = 16'hFED1;
            6'd33:   f = 16'hFED5;
            6'd34:   f = 16'hFED9;
            6'd35:   f = 16'hFEDD;
            6'd36:   f = 16'hFEE1;
            6'd37:   f = 16'hFEE5;
            6'd38:   f = 16'hFEE9;
            6'd39:   f = 16'hFEED;
            6'd40:   f = 16'hFEEF;
            6'd41:   f = 16'hFEF1;
            default: f = 16'h0000;
        endcase
        return f;
    endfunction

    // joining class per letter index
    function automatic logic [1:0] join_class(input logic [5:0] idx);
        logic [1:0] jc;
        case (idx) inside
            [6'd1:6'd4], 6'd6, 6'd8, [6'd14:6'd17], 6'd39, 6'd40: jc = JC_RIGHT;
            6'd5, 6'd7, [6'd9:6'd13], [6'd18:6'd25], [6'd32:6'd38], 6'd41: jc = JC_DUAL;
            default: jc = JC_NONE;
        endcase
        return jc;
    endfunction

    // lam-alef ligature base, zero when the code is none of the four alefs
    function automatic logic [15:0] lam_alef_base(input logic [15:0] code);
        logic [15:0] b;
        case (code)
            ALEF_MADDA:     b = LIG_MADDA;
            ALEF_HAMZA_UP:  b = LIG_HAMZA_UP;
            ALEF_HAMZA_LOW: b = LIG_HAMZA_LOW;
            ALEF_PLAIN:     b = LIG_PLAIN;
            default:        b = 16'h0000;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/arabic_contextual_shaper_unit.sv @@
// top level of the arabic contextual shaper: sequencer, run state and output register
//
//   channel | dir | fields (low bit up)              | handshake
//   s_axis  | in  | tdata: in_code[15:0]; tlast      | tvalid/tready
//   m_axis  | out | tdata: out_code[15:0]; tlast     | tvalid/tready
//
// an item is taken while idle and then resolved, both through the shared classifier;
// then the sequencer emits each letter form or passed code, and each buffered mark
// with a memory read, then output.
// reset clears the run state and the output register; no clearing pass.
// m_axis_tready low stalls the sequencer on its next emit; s_axis_tready is high
// only while the sequencer is idle.
`default_nettype none

module arabic_contextual_shaper_unit
    import acs_pkg::*;
#(
    parameter int MARK_DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // in_code[15:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_code[15:0]
    output logic             m_axis_tlast
);

    localparam int AW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int CW = $clog2(MARK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_EMIT_A,
        ST_MARK_RD,
        ST_MARK_OUT,
        ST_EMIT_CODE,
        ST_EMIT_B
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] code_reg, code_next;
    logic        last_reg, last_next;
    code_class_t cc_reg, cc_next;
    logic        full_reg, full_next;
    logic        held_valid_reg, held_valid_next;
    logic [15:0] held_letter_reg, held_letter_next;
    logic        held_jp_reg, held_jp_next;
    logic        prior_jf_reg, prior_jf_next;
    logic [CW-1:0] mark_count_reg, mark_count_next;
    logic [15:0] a_val_reg, a_val_next;
    logic [CW-1:0] mk_reg, mk_next;
    logic        pc_reg, pc_next;
    logic        pb_reg, pb_next;
    logic [15:0] b_val_reg, b_val_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_code_reg, out_code_next;
    logic        out_last_reg, out_last_next;

    logic        accept;
    logic        slot_free;
    logic [15:0] unit_code;
    code_class_t unit_info;
    logic        mark_wr;
    logic [15:0] mark_rd_data;

    // resolve terms
    logic        full;
    logic        res_now;
    logic        has_next;
    logic        lig;
    logic        jp;
    logic        jn;
    logic [1:0]  form_off;
    logic        new_held;
    logic        last_mark;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !out_valid_reg || m_axis_tready;

    // shared classifier: incoming code while idle, held letter while resolving
    assign unit_code = (state_reg == ST_IDLE) ? s_axis_tdata : held_letter_reg;

    acs_classifier u_classifier (
        .code (unit_code),
        .info (unit_info)
    );

    // marks that follow a held letter go into the buffer on accept
    assign mark_wr = accept && unit_info.transparent && held_valid_reg
                     && (mark_count_reg != CW'(MARK_DEPTH));

    acs_mark_store #(
        .DEPTH (MARK_DEPTH),
        .AW    (AW)
    ) u_mark_store (
        .clk     (clk),
        .wr_en   (mark_wr),
        .wr_addr (mark_count_reg[AW-1:0]),
        .wr_data (s_axis_tdata),
        .rd_addr (idx_reg),
        .rd_data (mark_rd_data)
    );

    // resolution of the held letter against the latched code
    always_comb
    begin
        full     = full_reg;
        res_now  = held_valid_reg && (!cc_reg.transparent || full || last_reg);
        has_next = held_valid_reg && !cc_reg.transparent;
        lig      = has_next && (held_letter_reg == LAM) && (cc_reg.lig != 16'h0000);
        jp       = held_jp_reg && (unit_info.jclass != JC_NONE);
        jn       = has_next && cc_reg.joins_back && (unit_info.jclass == JC_DUAL);
        if (jp && jn)
        begin
            form_off = FORM_MEDIAL;
        end
        else if (jp)
        begin
            form_off = FORM_FINAL;
        end
        else if (jn)
        begin
            form_off = FORM_INITIAL;
        end
        else
        begin
            form_off = FORM_ISOLATED;
        end
        new_held  = !cc_reg.transparent && !lig && cc_reg.letter;
        last_mark = ((CW'(idx_reg) + CW'(1)) == mk_reg);
    end

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        code_next        = code_reg;
        last_next        = last_reg;
        cc_next          = cc_reg;
        full_next        = full_reg;
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        held_jp_next     = held_jp_reg;
        prior_jf_next    = prior_jf_reg;
        mark_count_next  = mark_count_reg;
        a_val_next       = a_val_reg;
        mk_next          = mk_reg;
        pc_next          = pc_reg;
        pb_next          = pb_reg;
        b_val_next       = b_val_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_code_next    = out_code_reg;
        out_last_next    = out_last_reg;
        s_axis_tready    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    code_next  = s_axis_tdata;
                    last_next  = s_axis_tlast;
                    cc_next    = unit_info;
                    // mark that finds the buffer of a held letter already full
                    full_next  = unit_info.transparent && held_valid_reg
                                 && (mark_count_reg == CW'(MARK_DEPTH));
                    state_next = ST_RESOLVE;
                    if (mark_wr)
                    begin
                        mark_count_next = mark_count_reg + CW'(1);
                    end
                end
            end

            ST_RESOLVE:
            begin
                // plan of the items this code causes
                a_val_next = lig ? (cc_reg.lig + {15'd0, held_jp_reg})
                                 : (unit_info.iso + {14'd0, form_off});
                mk_next    = (res_now && !lig) ? mark_count_reg : '0;
                pc_next    = cc_reg.transparent ? (!held_valid_reg || full)
                                                : (!lig && !cc_reg.letter);
                pb_next    = new_held && last_reg;
                b_val_next = cc_reg.iso
                             + {15'd0, prior_jf_reg && (cc_reg.jclass != JC_NONE)};
                idx_next   = '0;

                // run state update
                if (last_reg)
                begin
                    held_valid_next  = 1'b0;
                    held_letter_next = '0;
                    held_jp_next     = 1'b0;
                    prior_jf_next    = 1'b0;
                    mark_count_next  = '0;
                end
                else
                begin
                    if (new_held)
                    begin
                        held_valid_next  = 1'b1;
                        held_letter_next = code_reg;
                        held_jp_next     = prior_jf_reg;
                        mark_count_next  = '0;
                    end
                    else if (res_now)
                    begin
                        held_valid_next = 1'b0;
                        mark_count_next = '0;
                    end
                    if (cc_reg.transparent)
                    begin
                        if (held_valid_reg && full)
                        begin
                            prior_jf_next = 1'b0;
                        end
                    end
                    else
                    begin
                        prior_jf_next = lig ? 1'b0 : cc_reg.joins_fwd;
                    end
                end

                if (res_now)
                begin
                    state_next = ST_EMIT_A;
                end
                else if (pc_next)
                begin
                    state_next = ST_EMIT_CODE;
                end
                else if (pb_next)
                begin
                    state_next = ST_EMIT_B;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT_A:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = a_val_reg;
                    out_last_next  = last_reg && (mk_reg == '0) && !pc_reg && !pb_reg;
                    if (mk_reg != '0)
                    begin
                        state_next = ST_MARK_RD;
                    end
                    else if (pc_reg)
                    begin
                        state_next = ST_EMIT_CODE;
                    end
                    else if (pb_reg)
                    begin
                        state_next = ST_EMIT_B;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_MARK_RD:
            begin
                state_next = ST_MARK_OUT;
            end

            ST_MARK_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = mark_rd_data;
                    out_last_next  = last_reg && last_mark && !pc_reg && !pb_reg;
                    if (!last_mark)
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_MARK_RD;
                    end
                    else if (pc_reg)
                    begin
                        state_next = ST_EMIT_CODE;
                    end
                    else if (pb_reg)
                    begin
                        state_next = ST_EMIT_B;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT_CODE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = code_reg;
                    out_last_next  = last_reg && !pb_reg;
                    state_next     = pb_reg ? ST_EMIT_B : ST_IDLE;
                end
            end

            ST_EMIT_B:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = b_val_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
            held_jp_reg     <= 1'b0;
            prior_jf_reg    <= 1'b0;
            mark_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
            held_jp_reg     <= held_jp_next;
            prior_jf_reg    <= prior_jf_next;
            mark_count_reg  <= mark_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        last_reg     <= last_next;
        cc_reg       <= cc_next;
        full_reg     <= full_next;
        a_val_reg    <= a_val_next;
        mk_reg       <= mk_next;
        pc_reg       <= pc_next;
        pb_reg       <= pb_next;
        b_val_reg    <= b_val_next;
        idx_reg      <= idx_next;
        out_code_reg <= out_code_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/acs_classifier.sv @@
// shared classifier: letter tables, joining behavior and ligature base of one code
`default_nettype none

module acs_classifier
    import acs_pkg::*;
(
    input  wire logic [15:0] code,
    output code_class_t      info
);

    logic [15:0] offset;
    logic [5:0]  idx;
    logic        in_range;
    logic [15:0] iso;
    logic [1:0]  jc;
    logic        letter;
    logic        tatweel;

    // table lookup over the letter block
    assign offset   = code - LETTER_FIRST;
    assign idx      = offset[5:0];
    assign in_range = (code >= LETTER_FIRST) && (code <= LETTER_LAST);
    assign iso      = iso_form(idx);
    assign jc       = join_class(idx);
    assign letter   = in_range && (iso != 16'h0000);
    assign tatweel  = (code == TATWEEL);

    // classification result
    always_comb
    begin
        info.transparent = ((code >= HARAKA_FIRST) && (code <= HARAKA_LAST))
                           || (code == SUPERSCRIPT_ALEF)
                           || ((code >= QURANIC_FIRST) && (code <= QURANIC_LAST));
        info.letter      = letter;
        info.joins_fwd   = tatweel || (letter && (jc == JC_DUAL));
        info.joins_back  = tatweel || (letter && (jc != JC_NONE));
        info.jclass      = letter ? jc : JC_NONE;
        info.iso         = iso;
        info.lig         = lam_alef_base(code);
    end

endmodule

`default_nettype wire

@@ rtl/core/acs_mark_store.sv @@
// mark buffer memory: one write port, one registered read port
`default_nettype none

module acs_mark_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic [15:0]        rd_data
);

    logic [15:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/acs_checker.sv @@
// port checker for the arabic shaper and its bind to the top level
`default_nettype none

`include "arabic_contextual_shaper_unit_macros.svh"

module acs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // a stalled output item holds
    `ACS_ASSERT_IMPL(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")

    // the block is busy on the cycle after it takes an item
    `ACS_ASSERT_IMPL(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input ready right after an accept")

    // output items only appear while an input item is being worked on
    `ACS_ASSERT_IMPL(a_out_from_work, clk, rst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "output item appeared while idle")

    // no item with tlast is taken right after another accept
    `ACS_ASSERT_NEVER(a_no_double_take, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast && $past(s_axis_tvalid && s_axis_tready), "two items taken back to back")

endmodule

bind arabic_contextual_shaper_unit acs_checker u_acs_checker (.*);

`default_nettype wire

@@ sim/arabic_contextual_shaper_unit_test.sv @@
// self-checking testbench for the arabic contextual shaper unit
`default_nettype none

module arabic_contextual_shaper_unit_test;
    import acs_pkg::*;

    localparam int MARK_SLOTS   = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 2 * MARK_SLOTS + 40;
    localparam int HOLD_OFF_LEN = 300;

    typedef struct {
        logic [15:0] code;
        logic        is_last;
    } shaped_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // letter info, indexed by codepoint minus the first letter
    logic [1:0]  jc_of [0:41];
    logic [15:0] iso_of [0:41];
    bit          letter_ok [0:41];

    // shaping state mirrored from the block
    bit          hold_on;
    logic [15:0] hold_code;
    bit          hold_joins_prev;
    bit          chain_fwd;
    logic [15:0] pending_marks [0:MARK_SLOTS-1];
    int          mark_n;

    shaped_t     step_out[$];
    shaped_t     shaped_q[$];
    logic [15:0] run_buf[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_left;
    int items_sent;
    int runs_sent;
    int results_checked;
    int fail_count;
    int cycle_count;

    arabic_contextual_shaper_unit #(
        .MARK_DEPTH(MARK_SLOTS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // fill letter info: isolated forms are packed back to back, one slot per form that the joining class allows
    task automatic build_letter_info();
        string       pat;
        logic [15:0] base;
        pat  = "01111212122222111122222222------2222222112";
        base = 16'hFE80;
        for (int i = 0; i < 42; i++)
        begin
            letter_ok[i] = (pat[i] != "-");
            iso_of[i]    = letter_ok[i] ? base : 16'h0000;
            case (pat[i])
                "0":
                begin
                    jc_of[i] = JC_NONE;
                    base     = base + 16'd1;
                end
                "1":
                begin
                    jc_of[i] = JC_RIGHT;
                    base     = base + 16'd2;
                end
                "2":
                begin
                    jc_of[i] = JC_DUAL;
                    base     = base + 16'd4;
                end
                default: jc_of[i] = JC_NONE;
            endcase
        end
    endtask

    function automatic bit mark_code(input logic [15:0] c);
        return (c >= HARAKA_FIRST && c <= HARAKA_LAST) || c == SUPERSCRIPT_ALEF ||
               (c >= QURANIC_FIRST && c <= QURANIC_LAST);
    endfunction

    function automatic bit letter_code(input logic [15:0] c);
        return c >= LETTER_FIRST && c <= LETTER_LAST && letter_ok[int'(c - LETTER_FIRST)];
    endfunction

    function automatic bit fwd_join(input logic [15:0] c);
        return c == TATWEEL || (letter_code(c) && jc_of[int'(c - LETTER_FIRST)] == JC_DUAL);
    endfunction

    function automatic bit back_join(input logic [15:0] c);
        return c == TATWEEL || (letter_code(c) && jc_of[int'(c - LETTER_FIRST)] != JC_NONE);
    endfunction

    function automatic void add_result(input logic [15:0] c);
        shaped_t r;
        r.code    = c;
        r.is_last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    // append one codepoint to the run being built
    function automatic void add_to_run(input logic [15:0] c);
        run_buf.insert(run_buf.size(), c);
    endfunction

    // emit the held letter and its buffered marks, or the lam-alef ligature
    task automatic release_held(input bit has_next, input logic [15:0] nxt, output bit absorbed);
        int          idx;
        logic [15:0] lig;
        bit          jp;
        bit          jn;
        logic [1:0]  form;
        idx = int'(hold_code - LETTER_FIRST);
        lig = 16'h0000;
        if (has_next)
        begin
            case (nxt)
                ALEF_MADDA:     lig = LIG_MADDA;
                ALEF_HAMZA_UP:  lig = LIG_HAMZA_UP;
                ALEF_HAMZA_LOW: lig = LIG_HAMZA_LOW;
                ALEF_PLAIN:     lig = LIG_PLAIN;
                default:        lig = 16'h0000;
            endcase
        end
        hold_on = 1'b0;
        if (hold_code == LAM && lig != 16'h0000)
        begin
            // marks between lam and alef are dropped
            add_result(hold_joins_prev ? lig + 16'd1 : lig);
            absorbed = 1'b1;
        end
        else
        begin
            jp = hold_joins_prev && jc_of[idx] != JC_NONE;
            jn = has_next && back_join(nxt) && jc_of[idx] == JC_DUAL;
            form = (jp && jn) ? FORM_MEDIAL : jp ? FORM_FINAL : jn ? FORM_INITIAL : FORM_ISOLATED;
            add_result(iso_of[idx] + 16'(form));
            for (int i = 0; i < mark_n; i++)
                add_result(pending_marks[i]);
            absorbed = 1'b0;
        end
        mark_n = 0;
    endtask

    // expected shaped codepoints for one accepted item
    task automatic shape_codepoint(input logic [15:0] code, input bit is_last);
        bit absorbed;
        step_out.delete();
        absorbed = 1'b0;
        if (mark_code(code))
        begin
            if (!hold_on)
                add_result(code);
            else if (mark_n < MARK_SLOTS)
            begin
                pending_marks[mark_n] = code;
                mark_n++;
            end
            else
            begin
                // mark buffer full: letter resolves unjoined forward, chain breaks
                release_held(1'b0, 16'h0000, absorbed);
                add_result(code);
                chain_fwd = 1'b0;
            end
        end
        else
        begin
            if (hold_on)
                release_held(1'b1, code, absorbed);
            if (absorbed)
                chain_fwd = 1'b0;
            else if (letter_code(code))
            begin
                hold_on         = 1'b1;
                hold_code       = code;
                hold_joins_prev = chain_fwd;
                mark_n          = 0;
                chain_fwd       = fwd_join(code);
            end
            else
            begin
                add_result(code);
                chain_fwd = fwd_join(code);
            end
        end
        // end of run flushes the hold and clears run state
        if (is_last)
        begin
            if (hold_on)
                release_held(1'b0, 16'h0000, absorbed);
            hold_on         = 1'b0;
            hold_code       = 16'h0000;
            hold_joins_prev = 1'b0;
            chain_fwd       = 1'b0;
            mark_n          = 0;
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].is_last = 1'b1;
        end
        foreach (step_out[i])
            shaped_q.insert(shaped_q.size(), step_out[i]);
    endtask

    // offer one item, with a random idle gap first
    task automatic send_code(input logic [15:0] code, input bit is_last);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= is_last;
        do @(posedge clk); while (!s_axis_tready);
        shape_codepoint(code, is_last);
        items_sent++;
        if (is_last)
            runs_sent++;
    endtask

    // send run_buf as one run, last flag on its final codepoint
    task automatic send_run_buf();
        foreach (run_buf[i])
            send_code(run_buf[i], i == run_buf.size() - 1);
    endtask

    function automatic logic [15:0] random_letter();
        int idx;
        do idx = $urandom_range(41); while (!letter_ok[idx]);
        return LETTER_FIRST + 16'(idx);
    endfunction

    function automatic logic [15:0] random_mark();
        case ($urandom_range(2))
            0: return 16'($urandom_range(int'(HARAKA_FIRST), int'(HARAKA_LAST)));
            1: return SUPERSCRIPT_ALEF;
            default: return 16'($urandom_range(int'(QURANIC_FIRST), int'(QURANIC_LAST)));
        endcase
    endfunction

    function automatic logic [15:0] random_alef();
        case ($urandom_range(3))
            0: return ALEF_MADDA;
            1: return ALEF_HAMZA_UP;
            2: return ALEF_HAMZA_LOW;
            default: return ALEF_PLAIN;
        endcase
    endfunction

    // mostly word-like text, some mark bursts and noise codepoints
    task automatic send_random_run();
        int kind;
        int k;
        run_buf.delete();
        repeat ($urandom_range(1, 8))
        begin
            kind = $urandom_range(99);
            if (kind < 40)
                add_to_run(random_letter());
            else if (kind < 52)
            begin
                add_to_run(LAM);
                if ($urandom_range(3) == 0)
                    add_to_run(random_mark());
                add_to_run(random_alef());
            end
            else if (kind < 70)
            begin
                if ($urandom_range(9) == 0)
                    k = $urandom_range(MARK_SLOTS - 1, MARK_SLOTS + 2);
                else
                    k = $urandom_range(1, 3);
                repeat (k) add_to_run(random_mark());
            end
            else if (kind < 77)
                add_to_run(TATWEEL);
            else if (kind < 85)
                add_to_run(16'($urandom_range(16'h0600, 16'h06FF)));
            else
                add_to_run(16'($urandom_range(16'hFFFF)));
        end
        send_run_buf();
    endtask

    // field extremes, marks with nothing held, non-letter gap codes
    task automatic test_extremes();
        run_buf = '{16'h0000};
        send_run_buf();
        run_buf = '{SUPERSCRIPT_ALEF, 16'h063B, 16'hFFFF};
        send_run_buf();
    endtask

    // isolated, initial, medial and final forms around marks and tatweel
    task automatic test_joining_forms();
        run_buf = '{16'h0628, 16'h064E, 16'h062A, TATWEEL, 16'h0647, 16'h0621, LETTER_LAST};
        send_run_buf();
    endtask

    // all four lam-alef ligatures, joined and unjoined, with a dropped mark
    task automatic test_lam_alef();
        run_buf = '{LAM, ALEF_MADDA};
        send_run_buf();
        run_buf = '{16'h0628, LAM, 16'h0651, ALEF_HAMZA_UP};
        send_run_buf();
        run_buf = '{LAM, ALEF_PLAIN, LAM, ALEF_HAMZA_LOW};
        send_run_buf();
    endtask

    // full mark buffer resolves a joined lam early, so the alef stays apart
    task automatic test_mark_overflow();
        run_buf = '{16'h0628, LAM};
        for (int i = 0; i < MARK_SLOTS; i++)
            add_to_run(HARAKA_FIRST + 16'(i));
        add_to_run(QURANIC_LAST);
        add_to_run(ALEF_PLAIN);
        send_run_buf();
    endtask

    task automatic test_random_text(input int s_pct, input int r_pct, input int target);
        int start;
        start              = items_sent;
        sender_idle_pct    = s_pct;
        receiver_stall_pct = r_pct;
        while (items_sent - start < target)
            send_random_run();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_output_hold_off();
        int start;
        start              = items_sent;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = HOLD_OFF_LEN;
        while (items_sent - start < 40)
            send_random_run();
    endtask

    // receiver: random stalls, or a counted hold-off when requested
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // compare each output item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (shaped_q.size() == 0)
            begin
                $error("unexpected item: out_code %h out_last %b", m_axis_tdata, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                shaped_t want;
                want = shaped_q.pop_front();
                results_checked++;
                if (m_axis_tdata !== want.code)
                begin
                    $error("out_code mismatch: expected %h, got %h", want.code, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.is_last)
                begin
                    $error("out_last mismatch: expected %b, got %b", want.is_last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still expected", cycle_count,
                     shaped_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = 16'h0000;
        s_axis_tlast       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = 0;
        items_sent         = 0;
        runs_sent          = 0;
        results_checked    = 0;
        fail_count         = 0;
        cycle_count        = 0;
        hold_on            = 1'b0;
        hold_code          = 16'h0000;
        hold_joins_prev    = 1'b0;
        chain_fwd          = 1'b0;
        mark_n             = 0;
        build_letter_info();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_joining_forms();
        test_lam_alef();
        test_mark_overflow();
        test_random_text(0, 0, 100);
        test_random_text(60, 0, 100);
        test_random_text(0, 60, 100);
        test_random_text(7, 7, 100);
        test_output_hold_off();

        // drain, then watch for stray output
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        receiver_stall_pct = 0;
        while (shaped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d codepoints in %0d runs sent, %0d shaped codepoints checked",
                 items_sent, runs_sent, results_checked);
        $display("covered joining forms, lam-alef ligatures, mark overflow, idle mixes, hold-off");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
